// File: hw/rtl/ranked_score_table_defines.svh
// ----------------------------------------------------------------------------
// Ranked score table assertion macros
// Shared property forms used by the concurrent checks of the score table.
// ----------------------------------------------------------------------------
`ifndef RANKED_SCORE_TABLE_DEFINES_SVH
`define RANKED_SCORE_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define RST_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define RST_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/rst_pkg.sv
// ----------------------------------------------------------------------------
// Ranked score table package
// Sizes, mode codes, entry types and address helpers of the score table.
// ----------------------------------------------------------------------------
package rst_pkg;

	localparam int SONG_TABLES  = 16;
	localparam int RANK_ENTRIES = 8;
	localparam int NAME_CHARS   = 8;
	localparam int LEVELS       = 3;

	localparam int TABLES  = SONG_TABLES * LEVELS;
	localparam int DEPTH   = TABLES * RANK_ENTRIES;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int TBL_W   = $clog2(TABLES + 1);
	localparam int IDX_W   = (RANK_ENTRIES > 1) ? $clog2(RANK_ENTRIES) : 1;
	localparam int CNT_W   = $clog2(RANK_ENTRIES + 1);
	localparam int NAME_W  = 8 * NAME_CHARS;
	localparam int SCORE_W = 32;

	localparam logic [1:0] LEVEL_INVALID = 2'd3;

	typedef enum logic [2:0] {
		MODE_INSERT     = 3'd0,
		MODE_QUERY      = 3'd1,
		MODE_CLEAR      = 3'd2,
		MODE_READ_ENTRY = 3'd3,
		MODE_READ_LAST  = 3'd4
	} mode_t;

	typedef struct packed {
		logic [NAME_W-1:0]  name;
		logic [SCORE_W-1:0] score;
	} entry_t;

	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
	} mem_req_t;

	function automatic logic [TBL_W-1:0] table_index(logic [3:0] song, logic [1:0] level);
		return TBL_W'((int'(song) % SONG_TABLES) * LEVELS + int'(level));
	endfunction

	function automatic logic [ADDR_W-1:0] entry_addr(logic [TBL_W-1:0] tbl,
		logic [IDX_W-1:0] idx);
		return ADDR_W'(int'(tbl) * RANK_ENTRIES + int'(idx));
	endfunction

endpackage

// File: hw/rtl/rst_cmp.sv
// ----------------------------------------------------------------------------
// Ranked score table compare unit
// Shared score comparator used by every step of the table walk.
// ----------------------------------------------------------------------------
module rst_cmp (
	input  logic [rst_pkg::SCORE_W-1:0] operand,
	input  logic [rst_pkg::SCORE_W-1:0] against,
	output logic                        lt,
	output logic                        zero
);

	assign lt   = operand < against;
	assign zero = operand == '0;

endmodule

// File: hw/rtl/rst_mem.sv
// ----------------------------------------------------------------------------
// Ranked score table entry memory
// Simple dual-port store of names and scores with a registered read port.
// ----------------------------------------------------------------------------
module rst_mem (
	input  logic              clk,
	input  rst_pkg::mem_req_t req,
	input  rst_pkg::entry_t   wr_data,
	output rst_pkg::entry_t   rd_data
);

	logic [rst_pkg::SCORE_W-1:0] score_mem [rst_pkg::DEPTH];
	logic [rst_pkg::NAME_W-1:0]  name_mem  [rst_pkg::DEPTH];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			score_mem[req.wr_addr] <= wr_data.score;
			name_mem[req.wr_addr]  <= wr_data.name;
		end
		if (req.rd_en) begin
			rd_data.score <= score_mem[req.rd_addr];
			rd_data.name  <= name_mem[req.rd_addr];
		end
	end

endmodule

// File: hw/rtl/ranked_score_table.sv
// ----------------------------------------------------------------------------
// Ranked score table
// Bank of descending high-score tables, one per song and difficulty level.
// ----------------------------------------------------------------------------
// The input channel (in_valid, in_ready) carries one command word: insert,
// query, clear, read entry or read last name. The output channel (out_valid,
// out_ready) returns one result word per command, in order.
// Insert and query walk the eight entries of one table through the shared
// comparator, one memory read and at most one write per cycle. Read entry
// reads its slot in S_READ and then moves to S_FIN; the other commands go
// straight to S_FIN, which loads the result register. The block takes one
// command at a time; in_ready is high only while the sequencer is idle.
// The result sits in an output register, so the next command is accepted
// while it waits; if the receiver stalls longer, the next result holds in
// its final state until the output register is taken.
// Reset clears the output, the last player name and one valid bit per
// table; a table whose bit is clear reads as all zero, so no clearing pass
// is needed and the block is ready right after reset.
// ----------------------------------------------------------------------------
`include "ranked_score_table_defines.svh"

module ranked_score_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  mode,
	input  logic [3:0]  song_number,
	input  logic [1:0]  difficulty_level,
	input  logic [63:0] player_name,
	input  logic [31:0] new_score,
	input  logic [2:0]  entry_slot,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        status,
	output logic        was_inserted,
	output logic [2:0]  rank_position,
	output logic        beats_lowest,
	output logic [63:0] read_name,
	output logic [31:0] read_score
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_READ,
		S_FIN
	} state_t;

	state_t                          state_q;
	logic [2:0]                      mode_q;
	logic                            bad_q;
	logic [rst_pkg::TBL_W-1:0]       tbl_q;
	logic                            ok_q;
	logic [rst_pkg::NAME_W-1:0]      name_q;
	logic [rst_pkg::SCORE_W-1:0]     score_q;
	logic [rst_pkg::IDX_W-1:0]       slot_q;
	logic [rst_pkg::CNT_W-1:0]       rd_cnt_q;
	logic                            dv_s1;
	logic [rst_pkg::IDX_W-1:0]       idx_s1;
	logic                            found_q;
	logic [rst_pkg::IDX_W-1:0]       pos_q;
	rst_pkg::entry_t                 carry_q;
	logic [rst_pkg::SCORE_W-1:0]     low_q;
	logic [rst_pkg::TABLES-1:0]      tbl_valid_q;
	logic [rst_pkg::NAME_W-1:0]      last_player_q;
	logic                            out_valid_q;
	logic                            status_q;
	logic                            was_inserted_q;
	logic [2:0]                      rank_position_q;
	logic                            beats_lowest_q;
	logic [63:0]                     read_name_q;
	logic [31:0]                     read_score_q;

	logic                            accept;
	logic                            in_bad;
	logic [rst_pkg::TBL_W-1:0]       in_tbl;
	logic                            issue;
	logic                            last_step;
	logic                            fin_go;
	rst_pkg::mem_req_t               mem_req;
	rst_pkg::entry_t                 wr_data;
	rst_pkg::entry_t                 rd_data;
	rst_pkg::entry_t                 ent;
	logic [rst_pkg::SCORE_W-1:0]     cmp_operand;
	logic                            cmp_lt;
	logic                            cmp_zero;

	logic                            res_status;
	logic                            res_ins;
	logic [2:0]                      res_rank;
	logic                            res_beats;
	logic [63:0]                     res_name;
	logic [31:0]                     res_score;

	assign in_ready  = state_q == S_IDLE;
	assign accept    = in_valid && in_ready;
	assign in_bad    = (mode < 3'(rst_pkg::MODE_READ_LAST)) &&
		(difficulty_level == rst_pkg::LEVEL_INVALID);
	assign in_tbl    = rst_pkg::table_index(song_number, difficulty_level);
	assign issue     = (state_q == S_WALK) && (rd_cnt_q < rst_pkg::CNT_W'(rst_pkg::RANK_ENTRIES));
	assign last_step = dv_s1 && (idx_s1 == rst_pkg::IDX_W'(rst_pkg::RANK_ENTRIES - 1));
	assign fin_go    = (state_q == S_FIN) && (!out_valid_q || out_ready);

	assign ent.score = ok_q ? rd_data.score : '0;
	assign ent.name  = ok_q ? rd_data.name : '0;

	assign cmp_operand = (state_q == S_FIN) ? low_q : ent.score;

	rst_cmp u_cmp (
		.operand (cmp_operand),
		.against (score_q),
		.lt      (cmp_lt),
		.zero    (cmp_zero)
	);

	always_comb begin
		mem_req.rd_en   = issue || (state_q == S_READ);
		mem_req.rd_addr = rst_pkg::entry_addr(tbl_q,
			(state_q == S_READ) ? slot_q : rd_cnt_q[rst_pkg::IDX_W-1:0]);
		mem_req.wr_en   = dv_s1 && (state_q == S_WALK) &&
			(mode_q == 3'(rst_pkg::MODE_INSERT)) && (found_q || cmp_lt);
		mem_req.wr_addr = rst_pkg::entry_addr(tbl_q, idx_s1);
		wr_data.name    = found_q ? carry_q.name : name_q;
		wr_data.score   = found_q ? carry_q.score : score_q;
	end

	rst_mem u_mem (
		.clk     (clk),
		.req     (mem_req),
		.wr_data (wr_data),
		.rd_data (rd_data)
	);

	always_comb begin
		res_status = 1'b0;
		res_ins    = 1'b0;
		res_rank   = '0;
		res_beats  = 1'b0;
		res_name   = '0;
		res_score  = '0;
		if (bad_q) begin
			res_status = 1'b1;
		end else begin
			unique case (mode_q)
				3'(rst_pkg::MODE_INSERT): begin
					res_ins  = found_q;
					res_rank = found_q ? 3'(pos_q) : 3'd0;
				end
				3'(rst_pkg::MODE_QUERY): begin
					res_beats = cmp_lt;
				end
				3'(rst_pkg::MODE_READ_ENTRY): begin
					res_name  = 64'(ent.name);
					res_score = ent.score;
				end
				3'(rst_pkg::MODE_READ_LAST): begin
					res_name = 64'(last_player_q);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			mode_q          <= '0;
			bad_q           <= 1'b0;
			tbl_q           <= '0;
			ok_q            <= 1'b0;
			name_q          <= '0;
			score_q         <= '0;
			slot_q          <= '0;
			rd_cnt_q        <= '0;
			dv_s1           <= 1'b0;
			idx_s1          <= '0;
			found_q         <= 1'b0;
			pos_q           <= '0;
			carry_q         <= '0;
			low_q           <= '0;
			tbl_valid_q     <= '0;
			last_player_q   <= '0;
			out_valid_q     <= 1'b0;
			status_q        <= 1'b0;
			was_inserted_q  <= 1'b0;
			rank_position_q <= '0;
			beats_lowest_q  <= 1'b0;
			read_name_q     <= '0;
			read_score_q    <= '0;
		end else begin
			if (out_valid_q && out_ready && !fin_go) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						mode_q   <= mode;
						bad_q    <= in_bad;
						tbl_q    <= in_tbl;
						ok_q     <= (difficulty_level == rst_pkg::LEVEL_INVALID) ? 1'b0 :
							tbl_valid_q[in_tbl];
						name_q   <= player_name[rst_pkg::NAME_W-1:0];
						score_q  <= new_score;
						slot_q   <= rst_pkg::IDX_W'(int'(entry_slot) % rst_pkg::RANK_ENTRIES);
						rd_cnt_q <= '0;
						dv_s1    <= 1'b0;
						found_q  <= 1'b0;
						pos_q    <= '0;
						if (in_bad) begin
							state_q <= S_FIN;
						end else if (mode == 3'(rst_pkg::MODE_INSERT) ||
							mode == 3'(rst_pkg::MODE_QUERY)) begin
							state_q <= S_WALK;
						end else if (mode == 3'(rst_pkg::MODE_READ_ENTRY)) begin
							state_q <= S_READ;
						end else begin
							if (mode == 3'(rst_pkg::MODE_CLEAR)) begin
								tbl_valid_q[in_tbl] <= 1'b0;
							end
							state_q <= S_FIN;
						end
					end
				end
				S_WALK: begin
					dv_s1  <= issue;
					idx_s1 <= rd_cnt_q[rst_pkg::IDX_W-1:0];
					if (issue) begin
						rd_cnt_q <= rd_cnt_q + 1'b1;
					end
					if (dv_s1) begin
						if (mode_q == 3'(rst_pkg::MODE_INSERT)) begin
							if (found_q || cmp_lt) begin
								carry_q <= ent;
							end
							if (!found_q && cmp_lt) begin
								found_q <= 1'b1;
								pos_q   <= idx_s1;
							end
						end else if (idx_s1 == '0 || !cmp_zero) begin
							low_q <= ent.score;
						end
					end
					if (last_step) begin
						state_q <= S_FIN;
					end
				end
				S_READ: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (fin_go) begin
						out_valid_q     <= 1'b1;
						status_q        <= res_status;
						was_inserted_q  <= res_ins;
						rank_position_q <= res_rank;
						beats_lowest_q  <= res_beats;
						read_name_q     <= res_name;
						read_score_q    <= res_score;
						if (!bad_q && mode_q == 3'(rst_pkg::MODE_INSERT) && found_q) begin
							tbl_valid_q[tbl_q] <= 1'b1;
							last_player_q      <= name_q;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign was_inserted  = was_inserted_q;
	assign rank_position = rank_position_q;
	assign beats_lowest  = beats_lowest_q;
	assign read_name     = read_name_q;
	assign read_score    = read_score_q;

	`RST_ASSERT_NEXT(a_busy_after_accept, accept, !in_ready, "Block ready right after a word was accepted.")
	`RST_ASSERT_IMPL(a_write_only_in_walk, mem_req.wr_en, (state_q == S_WALK) && dv_s1 && !bad_q, "Entry memory written outside the table walk.")
	`RST_ASSERT_IMPL(a_insert_result_clean, out_valid && was_inserted, !status && !beats_lowest && (read_score == '0), "Insert result carries fields of another mode.")

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ranked score table testbench
// Feeds command words through the valid/ready input, predicts every result
// word from a private copy of all score tables and the last player name, and
// checks them in order; both sides stall at random but in the last phase.
// ----------------------------------------------------------------------------
module tb;

	localparam int CLOCK_LIMIT = 500000;
	localparam int TAIL_CYCLES = 24;

	typedef struct packed {
		logic [2:0]                  mode;
		logic [3:0]                  song;
		logic [1:0]                  level;
		logic [63:0]                 name;
		logic [rst_pkg::SCORE_W-1:0] score;
		logic [2:0]                  slot;
	} command_t;

	typedef struct packed {
		logic                        status;
		logic                        inserted;
		logic [2:0]                  rank;
		logic                        beats;
		logic [63:0]                 name;
		logic [rst_pkg::SCORE_W-1:0] score;
	} outcome_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  cmd_mode = '0;
	logic [3:0]  cmd_song = '0;
	logic [1:0]  cmd_level = '0;
	logic [63:0] cmd_name = '0;
	logic [31:0] cmd_score = '0;
	logic [2:0]  cmd_slot = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        res_status;
	logic        res_inserted;
	logic [2:0]  res_rank;
	logic        res_beats;
	logic [63:0] res_name;
	logic [31:0] res_score;

	rst_pkg::entry_t board [rst_pkg::TABLES][rst_pkg::RANK_ENTRIES] = '{default: '0};
	logic [63:0] last_name = '0;

	command_t command_queue [$];
	outcome_t expected_outcomes [$];
	command_t offered;
	outcome_t want;
	logic [3:0] hot_songs [3];

	int send_idle = 0;
	int recv_idle = 0;
	int items_queued = 0;
	int accepted = 0;
	int errors = 0;
	int cycles = 0;
	int hold_len = 0;
	int hold_seq = 0;
	int hold_seen = 0;
	int hold_left = 0;

	ranked_score_table i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.mode             (cmd_mode),
		.song_number      (cmd_song),
		.difficulty_level (cmd_level),
		.player_name      (cmd_name),
		.new_score        (cmd_score),
		.entry_slot       (cmd_slot),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.status           (res_status),
		.was_inserted     (res_inserted),
		.rank_position    (res_rank),
		.beats_lowest     (res_beats),
		.read_name        (res_name),
		.read_score       (res_score)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
	end

	function automatic outcome_t execute_command(command_t c);
		outcome_t r;
		logic [63:0] nm;
		int t;
		int pos;
		r = '0;
		nm = 64'(c.name[rst_pkg::NAME_W-1:0]);
		t = (int'(c.song) % rst_pkg::SONG_TABLES) * rst_pkg::LEVELS + int'(c.level);
		if (c.mode == rst_pkg::MODE_READ_LAST) begin
			r.name = last_name;
		end else if (c.mode > rst_pkg::MODE_READ_LAST) begin
			r = '0;
		end else if (c.level == rst_pkg::LEVEL_INVALID) begin
			r.status = 1'b1;
		end else begin
			unique case (c.mode)
				rst_pkg::MODE_INSERT: begin
					pos = 0;
					while (pos < rst_pkg::RANK_ENTRIES && board[t][pos].score >= c.score)
						pos++;
					if (pos < rst_pkg::RANK_ENTRIES) begin
						for (int k = rst_pkg::RANK_ENTRIES - 1; k > pos; k--)
							board[t][k] = board[t][k-1];
						board[t][pos].name = rst_pkg::NAME_W'(nm);
						board[t][pos].score = c.score;
						last_name = nm;
						r.inserted = 1'b1;
						r.rank = 3'(pos);
					end
				end
				rst_pkg::MODE_QUERY: begin
					pos = rst_pkg::RANK_ENTRIES - 1;
					while (pos > 0 && board[t][pos].score == '0)
						pos--;
					r.beats = (c.score > board[t][pos].score);
				end
				rst_pkg::MODE_CLEAR: begin
					for (int k = 0; k < rst_pkg::RANK_ENTRIES; k++)
						board[t][k] = '0;
				end
				default: begin
					pos = int'(c.slot) % rst_pkg::RANK_ENTRIES;
					r.name = 64'(board[t][pos].name);
					r.score = board[t][pos].score;
				end
			endcase
		end
		return r;
	endfunction

	function automatic command_t make_command(logic [2:0] m, logic [3:0] s, logic [1:0] l,
		logic [63:0] n, logic [31:0] sc, logic [2:0] sl);
		command_t c;
		c.mode = m;
		c.song = s;
		c.level = l;
		c.name = n;
		c.score = sc;
		c.slot = sl;
		return c;
	endfunction

	function automatic command_t random_command();
		command_t c;
		int pick;
		pick = $urandom_range(99);
		if (pick < 45) c.mode = rst_pkg::MODE_INSERT;
		else if (pick < 60) c.mode = rst_pkg::MODE_QUERY;
		else if (pick < 63) c.mode = rst_pkg::MODE_CLEAR;
		else if (pick < 85) c.mode = rst_pkg::MODE_READ_ENTRY;
		else if (pick < 95) c.mode = rst_pkg::MODE_READ_LAST;
		else c.mode = 3'($urandom_range(7, int'(rst_pkg::MODE_READ_LAST) + 1));
		c.song = ($urandom_range(99) < 75) ? hot_songs[$urandom_range(2)] : 4'($urandom);
		c.level = ($urandom_range(99) < 6) ? rst_pkg::LEVEL_INVALID : 2'($urandom_range(2));
		c.name = {$urandom, $urandom};
		pick = $urandom_range(99);
		if (pick < 40) c.score = 32'($urandom_range(12, 1)) * 32'd1000;
		else if (pick < 48) c.score = '0;
		else if (pick < 54) c.score = '1;
		else c.score = $urandom;
		c.slot = 3'($urandom);
		return c;
	endfunction

	task automatic enqueue(command_t c);
		command_queue.push_back(c);
		items_queued++;
	endtask

	task automatic enqueue_random(int count);
		for (int i = 0; i < count; i++)
			enqueue(random_command());
	endtask

	task automatic pick_hot_songs();
		for (int i = 0; i < 3; i++)
			hot_songs[i] = 4'($urandom);
	endtask

	task automatic wait_drained();
		while (accepted != items_queued || expected_outcomes.size() != 0)
			@(negedge clk);
	endtask

	// Driver: the prediction is taken at the edge where the word is accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				expected_outcomes.push_back(execute_command(offered));
				accepted++;
			end
			if (!in_valid || in_ready) begin
				if (command_queue.size() != 0 && $urandom_range(99) >= send_idle) begin
					offered = command_queue.pop_front();
					cmd_mode <= offered.mode;
					cmd_song <= offered.song;
					cmd_level <= offered.level;
					cmd_name <= offered.name;
					cmd_score <= offered.score;
					cmd_slot <= offered.slot;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_seen <= 0;
			hold_left <= 0;
		end else if (hold_seq != hold_seen) begin
			hold_seen <= hold_seq;
			hold_left <= hold_len;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Monitor: checks each result word against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_outcomes.size() == 0) begin
					$error("result word with no command outstanding");
					errors++;
				end else begin
					want = expected_outcomes.pop_front();
					if (res_status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, res_status);
						errors++;
					end
					if (res_inserted !== want.inserted) begin
						$error("was_inserted: expected %0d, got %0d", want.inserted, res_inserted);
						errors++;
					end
					if (res_rank !== want.rank) begin
						$error("rank_position: expected %0d, got %0d", want.rank, res_rank);
						errors++;
					end
					if (res_beats !== want.beats) begin
						$error("beats_lowest: expected %0d, got %0d", want.beats, res_beats);
						errors++;
					end
					if (res_name !== want.name) begin
						$error("read_name: expected %h, got %h", want.name, res_name);
						errors++;
					end
					if (res_score !== want.score) begin
						$error("read_score: expected %h, got %h", want.score, res_score);
						errors++;
					end
				end
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	initial begin
		while (cycles < CLOCK_LIMIT)
			@(posedge clk);
		$display("FAIL ranked_score_table");
		$finish;
	end

	initial begin
		int m;
		send_idle = 11;
		recv_idle = 82;
		pick_hot_songs();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		enqueue(make_command(rst_pkg::MODE_READ_LAST, 4'd0, rst_pkg::LEVEL_INVALID, '0, '0,
			3'd0));
		enqueue(make_command(rst_pkg::MODE_QUERY, 4'd0, 2'd0, '0, 32'd0, 3'd0));
		enqueue(make_command(rst_pkg::MODE_QUERY, 4'd0, 2'd0, '0, 32'd1, 3'd0));
		enqueue(make_command(rst_pkg::MODE_INSERT, 4'd0, 2'd0, 64'h41, 32'd0, 3'd0));
		enqueue(make_command(rst_pkg::MODE_INSERT, 4'd15, 2'd2, '1, '1, 3'd7));
		enqueue(make_command(rst_pkg::MODE_INSERT, 4'd15, 2'd2, 64'h4242, '1, 3'd0));
		enqueue(make_command(rst_pkg::MODE_INSERT, 4'd15, 2'd2, 64'h434343, 32'd1, 3'd0));
		enqueue(make_command(rst_pkg::MODE_QUERY, 4'd15, 2'd2, '0, 32'd1, 3'd0));
		enqueue(make_command(rst_pkg::MODE_QUERY, 4'd15, 2'd2, '0, 32'd2, 3'd0));
		enqueue(make_command(rst_pkg::MODE_READ_ENTRY, 4'd15, 2'd2, '0, '0, 3'd0));
		enqueue(make_command(rst_pkg::MODE_READ_ENTRY, 4'd15, 2'd2, '0, '0, 3'd1));
		enqueue(make_command(rst_pkg::MODE_READ_ENTRY, 4'd15, 2'd2, '0, '0, 3'd7));
		enqueue(make_command(rst_pkg::MODE_READ_LAST, 4'd15, 2'd2, '1, '1, 3'd7));
		for (m = int'(rst_pkg::MODE_INSERT); m <= int'(rst_pkg::MODE_READ_ENTRY); m++)
			enqueue(make_command(3'(m), 4'd15, rst_pkg::LEVEL_INVALID, '1, '1, 3'd0));
		for (m = int'(rst_pkg::MODE_READ_LAST) + 1; m < 8; m++)
			enqueue(make_command(3'(m), 4'd15, 2'd2, '1, '1, 3'd7));
		enqueue(make_command(rst_pkg::MODE_CLEAR, 4'd15, 2'd2, '0, '0, 3'd0));
		enqueue(make_command(rst_pkg::MODE_READ_ENTRY, 4'd15, 2'd2, '0, '0, 3'd0));
		enqueue(make_command(rst_pkg::MODE_QUERY, 4'd15, 2'd2, '0, '1, 3'd0));
		wait_drained();

		enqueue_random(250);
		wait_drained();
		// Receiver holds off long enough for the block to back up its input.
		hold_len = 400;
		hold_seq++;
		enqueue_random(40);
		wait_drained();
		enqueue_random(260);
		wait_drained();

		send_idle = 82;
		recv_idle = 11;
		pick_hot_songs();
		enqueue_random(550);
		wait_drained();

		send_idle = 0;
		recv_idle = 0;
		pick_hot_songs();
		enqueue_random(575);
		wait_drained();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && expected_outcomes.size() == 0) begin
			$display("PASS ranked_score_table");
		end else begin
			$display("FAIL ranked_score_table");
		end
		$finish;
	end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/rst_pkg.sv
hw/rtl/rst_cmp.sv
hw/rtl/rst_mem.sv
hw/rtl/ranked_score_table.sv
tb/tb.sv
